// ===== rtl/core/lwaead_pkg.sv =====
// Shared types and constants for the Ascon-128/128a encryption block.
`default_nettype none
package lwaead_pkg;

	typedef logic [63:0] word_t;
	typedef logic [4:0][63:0] state_t;

	localparam word_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam word_t PAD_BYTE = 64'h8000_0000_0000_0000;
	localparam word_t IV_128   = 64'h8040_0c06_0000_0000;
	localparam word_t IV_128A  = 64'h8080_0c08_0000_0000;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_VARIANT    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_NONCE_HIGH = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_NONCE_LOW  = 3'd4;

	// Message phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_AD   = 2'd1;
	localparam logic [1:0] PH_PT   = 2'd2;

	// Input block kinds and result kinds
	localparam logic MODE_AD  = 1'b0;
	localparam logic MODE_PT  = 1'b1;
	localparam logic KIND_CT  = 1'b0;
	localparam logic KIND_TAG = 1'b1;

	// Round index of the final round of every permutation
	localparam logic [3:0] LAST_RND = 4'd11;

endpackage
`default_nettype wire

// ===== rtl/core/lwaead_in_if.sv =====
// Input block channel: valid/ready handshake with one data block per transaction.
`default_nettype none
interface lwaead_in_if;
	logic                valid;
	logic                ready;
	logic                mode;
	lwaead_pkg::word_t   data_high;
	lwaead_pkg::word_t   data_low;
	logic [4:0]          byte_count;
	logic                last_block;

	modport source (output valid, mode, data_high, data_low, byte_count, last_block,
		input ready);
	modport sink (input valid, mode, data_high, data_low, byte_count, last_block,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lwaead_out_if.sv =====
// Result channel: ciphertext blocks and tags, one per transaction.
`default_nettype none
interface lwaead_out_if;
	logic                valid;
	logic                ready;
	logic                word_kind;
	lwaead_pkg::word_t   word_high;
	lwaead_pkg::word_t   word_low;
	logic [4:0]          valid_bytes;
	logic                run_end;

	modport source (output valid, word_kind, word_high, word_low, valid_bytes, run_end,
		input ready);
	modport sink (input valid, word_kind, word_high, word_low, valid_bytes, run_end,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lwaead_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none
interface lwaead_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [lwaead_pkg::CFG_ADDR_W-1:0]    addr;
	lwaead_pkg::word_t                    wdata;

	modport source (output valid, addr, wdata, input ready);
	modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lwaead_round.sv =====
// One Ascon permutation round: constant addition, S-box layer, linear layer.
`default_nettype none
module lwaead_round (
	input  lwaead_pkg::state_t  s_in,
	input  logic [3:0]          rnd,
	output lwaead_pkg::state_t  s_out
);

	lwaead_pkg::word_t x0, x1, x2, x3, x4;
	lwaead_pkg::word_t t0, t1, t2, t3, t4;
	logic [7:0]        rc;

	// Round constant: high nibble counts down, low nibble counts up
	assign rc = {4'd15 - rnd, rnd};

	always_comb begin
		x0 = s_in[0];
		x1 = s_in[1];
		x2 = s_in[2] ^ {56'd0, rc};
		x3 = s_in[3];
		x4 = s_in[4];

		// S-box, bitsliced over the five words
		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 = x0 ^ t1;
		x1 = x1 ^ t2;
		x2 = x2 ^ t3;
		x3 = x3 ^ t4;
		x4 = x4 ^ t0;
		x1 = x1 ^ x0;
		x0 = x0 ^ x4;
		x3 = x3 ^ x2;
		x2 = ~x2;

		// Linear diffusion, rotate right by fixed amounts
		s_out[0] = x0 ^ {x0[18:0], x0[63:19]} ^ {x0[27:0], x0[63:28]};
		s_out[1] = x1 ^ {x1[60:0], x1[63:61]} ^ {x1[38:0], x1[63:39]};
		s_out[2] = x2 ^ {x2[0],    x2[63:1]}  ^ {x2[5:0],  x2[63:6]};
		s_out[3] = x3 ^ {x3[9:0],  x3[63:10]} ^ {x3[16:0], x3[63:17]};
		s_out[4] = x4 ^ {x4[6:0],  x4[63:7]}  ^ {x4[40:0], x4[63:41]};
	end

endmodule
`default_nettype wire

// ===== rtl/core/lightweight_aead_encryptor.sv =====
// Ascon-128 / Ascon-128a encryption top level with round sequencer and output register.
//
// Usage: write variant, key and nonce over cfg while no message transaction is pending.
// Feed associated-data blocks (mode 0) then plaintext blocks (mode 1) on item; the
// block marked last_block of each kind is padded. Ciphertext blocks and the tag leave
// on result, run_end marking the last result of an input transaction.
// Timing: one permutation round per cycle in a single shared round unit, 6 or 8 rounds
// per block. An accepted item passes through dispatch before its rounds, and a plaintext
// block's ciphertext is registered as its block rounds begin. The first item of a
// message adds an initialization of 12 rounds. A short last plaintext block runs 12
// finalization rounds before its tag is registered; a last block that fills
// the rate runs as a full block followed by an empty padded one. item.ready is high
// only while the sequencer is idle, one item in flight at a time.
// A single output register holds each result; when the receiver stalls the
// sequencer waits at the next emission, so no result is lost or repeated.
// Reset (arst_n low) clears configuration to zero and returns the message to the
// idle phase; the next item starts a new message. cfg is always ready.
`default_nettype none
module lightweight_aead_encryptor (
	input  wire           clk,
	input  wire           arst_n,
	lwaead_in_if.sink     item,
	lwaead_out_if.source  result,
	lwaead_cfg_if.sink    cfg
);

	// Sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_CT_FULL  = 3'd2;
	localparam logic [2:0] ST_PT_LAST  = 3'd3;
	localparam logic [2:0] ST_ROUND    = 3'd4;
	localparam logic [2:0] ST_POST     = 3'd5;

	// Action after a permutation completes
	localparam logic [2:0] POST_INIT    = 3'd0;
	localparam logic [2:0] POST_AD_FULL = 3'd1;
	localparam logic [2:0] POST_AD_PAD  = 3'd2;
	localparam logic [2:0] POST_PT_FULL = 3'd3;
	localparam logic [2:0] POST_TAG     = 3'd4;

	// Control registers
	logic [2:0] state_q, state_d;
	logic [2:0] post_q, post_d;
	logic [1:0] phase_q, phase_d;
	logic [3:0] rnd_q, rnd_d;
	logic       out_valid_q, out_valid_d;

	// Configuration
	logic              variant_q;
	lwaead_pkg::word_t key_high_q, key_low_q, nonce_high_q, nonce_low_q;

	// Cipher state and captured item
	lwaead_pkg::state_t s_q, s_d, s_rnd;
	logic              mode_q, mode_d;
	lwaead_pkg::word_t hi_q, hi_d, lo_q, lo_d;
	logic [4:0]        cnt_q, cnt_d;
	logic              last_q, last_d;

	// Output register payload
	logic              kind_q, kind_d;
	lwaead_pkg::word_t ohi_q, ohi_d, olo_q, olo_d;
	logic [4:0]        obytes_q, obytes_d;
	logic              oend_q, oend_d;

	// Helpers
	logic              item_accept, out_free, full_blk;
	logic [4:0]        rate;
	logic [3:0]        brnd_start;
	logic [5:0]        sh;
	lwaead_pkg::word_t hmask, padb, pad_p0, pad_p1, ct0, ct1;

	lwaead_round u_round (
		.s_in  (s_q),
		.rnd   (rnd_q),
		.s_out (s_rnd)
	);

	assign item.ready    = (state_q == ST_IDLE);
	assign item_accept   = item.valid & item.ready;
	assign cfg.ready     = 1'b1;
	assign out_free      = ~out_valid_q | result.ready;

	assign result.valid       = out_valid_q;
	assign result.word_kind   = kind_q;
	assign result.word_high   = ohi_q;
	assign result.word_low    = olo_q;
	assign result.valid_bytes = obytes_q;
	assign result.run_end     = oend_q;

	// Rate, round count, padding and partial-block masks
	assign rate       = variant_q ? 5'd16 : 5'd8;
	assign brnd_start = variant_q ? 4'd4 : 4'd6;
	assign full_blk   = ~last_q | (cnt_q >= rate);
	assign sh         = {cnt_q[2:0], 3'b000};
	assign hmask      = ~(lwaead_pkg::ALL_ONES >> sh);
	assign padb       = lwaead_pkg::PAD_BYTE >> sh;
	assign pad_p0     = cnt_q[3] ? hi_q : ((hi_q & hmask) | padb);
	assign pad_p1     = cnt_q[3] ? ((lo_q & hmask) | padb) : 64'd0;
	assign ct0        = cnt_q[3] ? s_q[0] : (s_q[0] & hmask);
	assign ct1        = cnt_q[3] ? (s_q[1] & hmask) : 64'd0;

	// Sequencer next state
	always_comb begin
		state_d     = state_q;
		post_d      = post_q;
		phase_d     = phase_q;
		rnd_d       = rnd_q;
		s_d         = s_q;
		mode_d      = mode_q;
		hi_d        = hi_q;
		lo_d        = lo_q;
		cnt_d       = cnt_q;
		last_d      = last_q;
		out_valid_d = out_valid_q & ~result.ready;
		kind_d      = kind_q;
		ohi_d       = ohi_q;
		olo_d       = olo_q;
		obytes_d    = obytes_q;
		oend_d      = oend_q;

		case (state_q)
			ST_IDLE: begin
				if (item_accept) begin
					mode_d = item.mode;
					hi_d   = item.data_high;
					lo_d   = item.data_low;
					cnt_d  = item.byte_count;
					last_d = item.last_block;
					if (phase_q == lwaead_pkg::PH_IDLE) begin
						// New message: load IV, key, nonce and run 12 rounds
						s_d[0]  = variant_q ? lwaead_pkg::IV_128A : lwaead_pkg::IV_128;
						s_d[1]  = key_high_q;
						s_d[2]  = key_low_q;
						s_d[3]  = nonce_high_q;
						s_d[4]  = nonce_low_q;
						rnd_d   = 4'd0;
						post_d  = POST_INIT;
						state_d = ST_ROUND;
					end else begin
						state_d = ST_DISPATCH;
					end
				end
			end
			ST_DISPATCH: begin
				if (mode_q == lwaead_pkg::MODE_AD) begin
					if (phase_q != lwaead_pkg::PH_AD) begin
						// Associated data after plaintext is dropped
						state_d = ST_IDLE;
					end else begin
						if (full_blk) begin
							s_d[0] = s_q[0] ^ hi_q;
							if (variant_q) s_d[1] = s_q[1] ^ lo_q;
							post_d = POST_AD_FULL;
						end else begin
							s_d[0] = s_q[0] ^ pad_p0;
							if (variant_q) s_d[1] = s_q[1] ^ pad_p1;
							post_d = POST_AD_PAD;
						end
						rnd_d   = brnd_start;
						state_d = ST_ROUND;
					end
				end else begin
					// Domain separation when no associated-data block closed the phase
					s_d[4]  = s_q[4] ^ {63'd0, phase_q == lwaead_pkg::PH_AD};
					phase_d = lwaead_pkg::PH_PT;
					if (full_blk) begin
						s_d[0] = s_q[0] ^ hi_q;
						if (variant_q) s_d[1] = s_q[1] ^ lo_q;
						state_d = ST_CT_FULL;
					end else begin
						s_d[0] = s_q[0] ^ pad_p0;
						if (variant_q) s_d[1] = s_q[1] ^ pad_p1;
						state_d = ST_PT_LAST;
					end
				end
			end
			ST_CT_FULL: begin
				// Full ciphertext block, then the block rounds
				if (out_free) begin
					out_valid_d = 1'b1;
					kind_d      = lwaead_pkg::KIND_CT;
					ohi_d       = s_q[0];
					olo_d       = variant_q ? s_q[1] : 64'd0;
					obytes_d    = rate;
					oend_d      = ~last_q;
					rnd_d       = brnd_start;
					post_d      = POST_PT_FULL;
					state_d     = ST_ROUND;
				end
			end
			ST_PT_LAST: begin
				// Partial ciphertext if any, key into the state, finalization rounds
				if ((cnt_q == 5'd0) || out_free) begin
					if (cnt_q != 5'd0) begin
						out_valid_d = 1'b1;
						kind_d      = lwaead_pkg::KIND_CT;
						ohi_d       = ct0;
						olo_d       = ct1;
						obytes_d    = cnt_q;
						oend_d      = 1'b0;
					end
					if (variant_q) begin
						s_d[2] = s_q[2] ^ key_high_q;
						s_d[3] = s_q[3] ^ key_low_q;
					end else begin
						s_d[1] = s_q[1] ^ key_high_q;
						s_d[2] = s_q[2] ^ key_low_q;
					end
					rnd_d   = 4'd0;
					post_d  = POST_TAG;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				s_d = s_rnd;
				if (rnd_q == lwaead_pkg::LAST_RND) begin
					state_d = ST_POST;
				end else begin
					rnd_d = rnd_q + 4'd1;
				end
			end
			ST_POST: begin
				case (post_q)
					POST_INIT: begin
						s_d[3]  = s_q[3] ^ key_high_q;
						s_d[4]  = s_q[4] ^ key_low_q;
						phase_d = lwaead_pkg::PH_AD;
						state_d = ST_DISPATCH;
					end
					POST_AD_FULL, POST_PT_FULL: begin
						// A last full block is followed by an empty padded block
						if (last_q) begin
							cnt_d   = 5'd0;
							state_d = ST_DISPATCH;
						end else begin
							state_d = ST_IDLE;
						end
					end
					POST_AD_PAD: begin
						s_d[4]  = s_q[4] ^ 64'd1;
						phase_d = lwaead_pkg::PH_PT;
						state_d = ST_IDLE;
					end
					POST_TAG: begin
						if (out_free) begin
							s_d[3]      = s_q[3] ^ key_high_q;
							s_d[4]      = s_q[4] ^ key_low_q;
							out_valid_d = 1'b1;
							kind_d      = lwaead_pkg::KIND_TAG;
							ohi_d       = s_q[3] ^ key_high_q;
							olo_d       = s_q[4] ^ key_low_q;
							obytes_d    = 5'd16;
							oend_d      = 1'b1;
							phase_d     = lwaead_pkg::PH_IDLE;
							state_d     = ST_IDLE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			post_q       <= POST_INIT;
			phase_q      <= lwaead_pkg::PH_IDLE;
			rnd_q        <= 4'd0;
			out_valid_q  <= 1'b0;
			variant_q    <= 1'b0;
			key_high_q   <= 64'd0;
			key_low_q    <= 64'd0;
			nonce_high_q <= 64'd0;
			nonce_low_q  <= 64'd0;
		end else begin
			state_q     <= state_d;
			post_q      <= post_d;
			phase_q     <= phase_d;
			rnd_q       <= rnd_d;
			out_valid_q <= out_valid_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					lwaead_pkg::REG_VARIANT:    variant_q    <= cfg.wdata[0];
					lwaead_pkg::REG_KEY_HIGH:   key_high_q   <= cfg.wdata;
					lwaead_pkg::REG_KEY_LOW:    key_low_q    <= cfg.wdata;
					lwaead_pkg::REG_NONCE_HIGH: nonce_high_q <= cfg.wdata;
					lwaead_pkg::REG_NONCE_LOW:  nonce_low_q  <= cfg.wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		s_q      <= s_d;
		mode_q   <= mode_d;
		hi_q     <= hi_d;
		lo_q     <= lo_d;
		cnt_q    <= cnt_d;
		last_q   <= last_d;
		kind_q   <= kind_d;
		ohi_q    <= ohi_d;
		olo_q    <= olo_d;
		obytes_q <= obytes_d;
		oend_q   <= oend_d;
	end

endmodule
`default_nettype wire
